/* src/assert_macros.svh */
// Assertion macros used by the RTL of the keystream block.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while the reset is high.
`define CKS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("%m: check failed");

// Clocked check that also holds during reset.
`define CKS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: check failed");

`else

`define CKS_ASSERT(lbl, clk_s, rst_s, prop)
`define CKS_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

/* src/cks_pkg.sv */
// Shared types, constants and the control program of the keystream block.
// No dependencies.
package cks_pkg;

  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned WORD_W    = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        widx_t;
  typedef logic [2:0]        pc_t;
  typedef logic [2:0]        reg_idx_t;

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

  localparam reg_idx_t REG_KEY_01  = 3'd0;
  localparam reg_idx_t REG_KEY_23  = 3'd1;
  localparam reg_idx_t REG_KEY_45  = 3'd2;
  localparam reg_idx_t REG_KEY_67  = 3'd3;
  localparam reg_idx_t REG_IV_01   = 3'd4;
  localparam reg_idx_t REG_IV_23   = 3'd5;
  localparam reg_idx_t REG_ROUNDS  = 3'd6;

  localparam logic [3:0] ROUNDS_RESET = 4'd10;

  // Program addresses.
  localparam pc_t STEP_IDLE   = 3'd0;
  localparam pc_t STEP_LOAD   = 3'd1;
  localparam pc_t STEP_ROUND  = 3'd2;
  localparam pc_t STEP_EMIT   = 3'd6;
  localparam pc_t STEP_FINISH = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ROUND,
    OP_EMIT,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_WAIT_REQ,
    BR_IF_NO_ROUNDS,
    BR_IF_MORE_ROUNDS,
    BR_WAIT_LAST
  } br_t;

  typedef struct packed {
    op_t  op;
    logic diag;
    logic second;
    br_t  br;
    pc_t  target;
  } uop_t;

  // Control store: one word per step.
  function automatic uop_t microcode(pc_t pc);
    uop_t u;
    u        = '0;
    u.op     = OP_NOP;
    u.br     = BR_NEXT;
    u.target = STEP_IDLE;
    unique case (pc)
      3'd0: begin
        u.br = BR_WAIT_REQ;
      end
      3'd1: begin
        u.op     = OP_LOAD;
        u.br     = BR_IF_NO_ROUNDS;
        u.target = STEP_EMIT;
      end
      3'd2: begin
        u.op = OP_ROUND;
      end
      3'd3: begin
        u.op     = OP_ROUND;
        u.second = 1'b1;
      end
      3'd4: begin
        u.op   = OP_ROUND;
        u.diag = 1'b1;
      end
      3'd5: begin
        u.op     = OP_ROUND;
        u.diag   = 1'b1;
        u.second = 1'b1;
        u.br     = BR_IF_MORE_ROUNDS;
        u.target = STEP_ROUND;
      end
      3'd6: begin
        u.op = OP_EMIT;
        u.br = BR_WAIT_LAST;
      end
      3'd7: begin
        u.op     = OP_FINISH;
        u.br     = BR_ALWAYS;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

/* src/cks_qr_half.sv */
// One half of a ChaCha quarter-round: two add, xor and rotate pairs.
// Depends on cks_pkg for the word type.
module cks_qr_half (
  input  cks_pkg::word_t quad_in  [4],
  input  logic           second,
  output cks_pkg::word_t quad_out [4]
);

  cks_pkg::word_t a1;
  cks_pkg::word_t x;
  cks_pkg::word_t d1;
  cks_pkg::word_t c1;
  cks_pkg::word_t y;
  cks_pkg::word_t b1;

  // The first half rotates by 16 and 12, the second by 8 and 7.
  always_comb begin
    a1 = quad_in[0] + quad_in[1];
    x  = quad_in[3] ^ a1;
    d1 = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
    c1 = quad_in[2] + d1;
    y  = quad_in[1] ^ c1;
    b1 = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
  end

  assign quad_out[0] = a1;
  assign quad_out[1] = b1;
  assign quad_out[2] = c1;
  assign quad_out[3] = d1;

endmodule

/* src/chacha_keystream_block.sv */
// ChaCha keystream block generator. A request is taken only when the sequencer is idle.
// The first word enters the output register at the emit step, which follows the load step
// and the round steps of R = double_rounds double rounds; a new request waits until the
// block finishes. The block rate is set by the single set of four half quarter-round
// units and by the output, one word per cycle while key_stall is low.
// Reset: synchronous, clears the sequencer, output valid, counter and registers.
// Depends on cks_pkg, cks_qr_half and assert_macros.svh.
`include "assert_macros.svh"

module chacha_keystream_block (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Request channel.
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        restart,
  // Keystream channel.
  output logic        key_valid,
  input  logic        key_stall,
  output logic [31:0] keystream_word,
  output logic [3:0]  word_index,
  output logic        last_word
);

  // Configuration registers.
  logic [63:0] key_01;
  logic [63:0] key_23;
  logic [63:0] key_45;
  logic [63:0] key_67;
  logic [63:0] iv_01;
  logic [63:0] iv_23;
  logic [3:0]  rounds;

  // Sequencer and datapath state. The working words need no reset because
  // the load step overwrites all of them before any round reads them.
  cks_pkg::pc_t   pc;
  cks_pkg::pc_t   pc_next;
  cks_pkg::uop_t  uop;
  logic [3:0]     rnd_cnt;
  cks_pkg::widx_t out_idx;
  logic [31:0]    block_counter;
  cks_pkg::word_t working    [cks_pkg::NUM_WORDS];
  cks_pkg::word_t init_words [cks_pkg::NUM_WORDS];
  cks_pkg::word_t round_next [cks_pkg::NUM_WORDS];
  cks_pkg::word_t qr_in      [4][4];
  cks_pkg::word_t qr_out     [4][4];

  logic req_accept;
  logic out_take;
  logic emit_fire;
  logic last_step;

  assign uop        = cks_pkg::microcode(pc);
  assign req_stall  = (pc != cks_pkg::STEP_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_take   = key_valid && !key_stall;

  // A word moves into the output register when it is empty or being drained.
  assign emit_fire = (uop.op == cks_pkg::OP_EMIT) && (!key_valid || !key_stall);
  assign last_step = uop.diag && uop.second;

  // Configuration writes. Indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01 <= '0;
      key_23 <= '0;
      key_45 <= '0;
      key_67 <= '0;
      iv_01  <= '0;
      iv_23  <= '0;
      rounds <= cks_pkg::ROUNDS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cks_pkg::REG_KEY_01: key_01 <= cfg_data;
        cks_pkg::REG_KEY_23: key_23 <= cfg_data;
        cks_pkg::REG_KEY_45: key_45 <= cfg_data;
        cks_pkg::REG_KEY_67: key_67 <= cfg_data;
        cks_pkg::REG_IV_01:  iv_01  <= cfg_data;
        cks_pkg::REG_IV_23:  iv_23  <= cfg_data;
        cks_pkg::REG_ROUNDS: rounds <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input state and output feed-forward operand, stable for a whole block if
  // configuration only changes while idle, which the user must ensure as the
  // block does not enforce it, and the counter moves only at the finish step.
  always_comb begin
    init_words[0]  = cks_pkg::SIGMA[0];
    init_words[1]  = cks_pkg::SIGMA[1];
    init_words[2]  = cks_pkg::SIGMA[2];
    init_words[3]  = cks_pkg::SIGMA[3];
    init_words[4]  = key_01[31:0];
    init_words[5]  = key_01[63:32];
    init_words[6]  = key_23[31:0];
    init_words[7]  = key_23[63:32];
    init_words[8]  = key_45[31:0];
    init_words[9]  = key_45[63:32];
    init_words[10] = key_67[31:0];
    init_words[11] = key_67[63:32];
    init_words[12] = block_counter;
    init_words[13] = iv_01[63:32];
    init_words[14] = iv_23[31:0];
    init_words[15] = iv_23[63:32];
  end

  // Four quarter-round lanes. In column mode lane l works on words l, l+4, l+8
  // and l+12; in diagonal mode the row at position p is shifted left by p.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    for (genvar p = 0; p < 4; p++) begin : g_pos
      localparam int IDX_C = p * 4 + l;
      localparam int IDX_D = p * 4 + ((l + p) % 4);
      assign qr_in[l][p] = uop.diag ? working[IDX_D] : working[IDX_C];
    end
    cks_qr_half u_qr (
      .quad_in  (qr_in[l]),
      .second   (uop.second),
      .quad_out (qr_out[l])
    );
  end

  // Route lane results back to their words.
  always_comb begin
    int pos;
    int lane_c;
    int lane_d;
    for (int j = 0; j < cks_pkg::NUM_WORDS; j++) begin
      pos    = j / 4;
      lane_c = j % 4;
      lane_d = (j % 4 - pos + 4) % 4;
      round_next[j] = uop.diag ? qr_out[lane_d][pos] : qr_out[lane_c][pos];
    end
  end

  // Branch unit of the sequencer.
  always_comb begin
    unique case (uop.br)
      cks_pkg::BR_NEXT:           pc_next = pc + 3'd1;
      cks_pkg::BR_ALWAYS:         pc_next = uop.target;
      cks_pkg::BR_WAIT_REQ:       pc_next = req_accept ? pc + 3'd1 : pc;
      cks_pkg::BR_IF_NO_ROUNDS:   pc_next = (rounds == 4'd0) ? uop.target : pc + 3'd1;
      cks_pkg::BR_IF_MORE_ROUNDS: pc_next = (rnd_cnt != 4'd1) ? uop.target : pc + 3'd1;
      cks_pkg::BR_WAIT_LAST:      pc_next = (emit_fire && (out_idx == 4'd15)) ? pc + 3'd1
                                                                                : pc;
      default:                    pc_next = cks_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cks_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Working state: loaded with the input state, then one half quarter-round
  // pass per round step.
  always_ff @(posedge clk) begin
    if (uop.op == cks_pkg::OP_LOAD) begin
      working <= init_words;
    end else if (uop.op == cks_pkg::OP_ROUND) begin
      working <= round_next;
    end
  end

  // Double-round counter, counted down at the end of each diagonal round.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_cnt <= '0;
    end else if (uop.op == cks_pkg::OP_LOAD) begin
      rnd_cnt <= rounds;
    end else if ((uop.op == cks_pkg::OP_ROUND) && last_step) begin
      rnd_cnt <= rnd_cnt - 4'd1;
    end
  end

  // The stored counter is reloaded on a restart request and advances once per
  // block at the finish step, wrapping at 32 bits with no carry into word 13.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (req_accept && restart) begin
      block_counter <= iv_01[31:0];
    end else if (uop.op == cks_pkg::OP_FINISH) begin
      block_counter <= block_counter + 32'd1;
    end
  end

  // Output word index, and the output register that decouples the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx   <= '0;
      key_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_idx   <= out_idx + 4'd1;
        key_valid <= 1'b1;
      end else if (out_take) begin
        key_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      keystream_word <= working[out_idx] + init_words[out_idx];
      word_index     <= out_idx;
      last_word      <= (out_idx == 4'd15);
    end
  end

  // A taken request always starts the load step.
  `CKS_ASSERT(a_req_to_load, clk, rst, req_accept |=> (pc == cks_pkg::STEP_LOAD))
  // An output word that raises key_valid comes only from the emit step.
  `CKS_ASSERT(a_emit_source, clk, rst, $rose(key_valid) |-> ($past(uop.op) == cks_pkg::OP_EMIT))
  // Round steps never run with an exhausted round count.
  `CKS_ASSERT(a_rounds_live, clk, rst, (uop.op == cks_pkg::OP_ROUND) |-> (rnd_cnt != 4'd0))
  // The counter moves only on a restart request or at the end of a block.
  `CKS_ASSERT(a_counter_moves, clk, rst, (!$past(rst) && !$stable(block_counter)) |-> ($past(uop.op == cks_pkg::OP_FINISH) || $past(req_accept && restart)))

endmodule
